// ----- src/upr_pkg.sv -----
`default_nettype none
package upr_pkg;

  // Field and register widths.
  localparam int TICK_W = 16;
  localparam int BYTE_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_BIT_TICKS     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_BYTE   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PACKET_LENGTH = 2'd2;

  // Byte queue between the bit receiver and the packet framer.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  // One received character as handed from the front to the back.
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              perr;
  } byte_rec_t;

endpackage
`default_nettype wire

// ----- src/upr_front.sv -----
`default_nettype none
module upr_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic                          rx_level,
  input  wire logic [upr_pkg::TICK_W-1:0]    bit_ticks,
  output logic                               push,
  output upr_pkg::byte_rec_t                 rec
);
  import upr_pkg::*;

  localparam logic [2:0] MODE_HUNT_LOW    = 3'd0;
  localparam logic [2:0] MODE_HUNT_HIGH   = 3'd1;
  localparam logic [2:0] MODE_CHECK_STOP1 = 3'd2;
  localparam logic [2:0] MODE_CHECK_STOP2 = 3'd3;
  localparam logic [2:0] MODE_WAIT_START  = 3'd4;
  localparam logic [2:0] MODE_START_DELAY = 3'd5;
  localparam logic [2:0] MODE_DATA        = 3'd6;
  localparam logic [2:0] MODE_POST_DELAY  = 3'd7;

  localparam logic [3:0] FRAME_BITS      = 4'd9;
  localparam logic [3:0] STOP_CHECK_BITS = 4'd9;

  logic [2:0]        rx_mode, rx_mode_next;
  logic [TICK_W-1:0] tick_count, tick_count_next;
  logic [3:0]        bit_count, bit_count_next;
  logic [8:0]        shift_bits, shift_bits_next;
  logic              ones_parity, ones_parity_next;

  logic [TICK_W-1:0] full_bit, half_bit, two_half;
  logic [TICK_W-1:0] dd_tick;
  logic [3:0]        dd_bit;
  logic              dd_done;
  logic [3:0]        tb_bc, tb_bc1;
  logic [8:0]        tb_shift;
  logic              tb_par;

  // Bit period with the floor of two, and the half bit derived from it.
  assign full_bit = (bit_ticks < TICK_W'(2)) ? TICK_W'(2) : bit_ticks;
  assign half_bit = {1'b0, full_bit[TICK_W-1:1]};
  assign two_half = {full_bit[TICK_W-1:1], 1'b0};

  // One tick of a delay of tick_count plus bit_count whole bits.
  always_comb begin
    dd_tick = tick_count;
    dd_bit  = bit_count;
    dd_done = 1'b0;
    if (tick_count == '0 && bit_count == '0) begin
      dd_done = 1'b1;
    end else begin
      if (tick_count == '0) begin
        dd_bit  = bit_count - 4'd1;
        dd_tick = full_bit;
      end
      dd_tick = dd_tick - TICK_W'(1);
      dd_done = (dd_tick == '0) && (dd_bit == '0);
    end
  end

  // Sampling of one frame bit, MSB first; the start delay begins at bit zero.
  always_comb begin
    tb_bc    = (rx_mode == MODE_START_DELAY) ? 4'd0 : bit_count;
    tb_shift = shift_bits;
    tb_par   = ones_parity;
    if (rx_level && tb_bc < FRAME_BITS) begin
      tb_shift = shift_bits | (9'h100 >> tb_bc);
      tb_par   = ~ones_parity;
    end
    tb_bc1 = tb_bc + 4'd1;
  end

  // Line state machine, advanced once per accepted sample.
  always_comb begin
    rx_mode_next     = rx_mode;
    tick_count_next  = tick_count;
    bit_count_next   = bit_count;
    shift_bits_next  = shift_bits;
    ones_parity_next = ones_parity;
    push             = 1'b0;
    rec.perr         = tb_par;
    rec.value        = tb_par ? '0 : tb_shift[8:1];
    if (accept) begin
      case (rx_mode)
        MODE_HUNT_LOW: begin
          if (!rx_level) rx_mode_next = MODE_HUNT_HIGH;
        end
        MODE_HUNT_HIGH: begin
          if (rx_level) begin
            rx_mode_next    = MODE_CHECK_STOP1;
            tick_count_next = half_bit;
            bit_count_next  = STOP_CHECK_BITS;
          end
        end
        MODE_CHECK_STOP1, MODE_CHECK_STOP2: begin
          tick_count_next = dd_tick;
          bit_count_next  = dd_bit;
          if (dd_done) begin
            if (!rx_level) begin
              rx_mode_next    = MODE_CHECK_STOP1;
              tick_count_next = two_half;
              bit_count_next  = STOP_CHECK_BITS;
            end else if (rx_mode == MODE_CHECK_STOP1) begin
              rx_mode_next    = MODE_CHECK_STOP2;
              tick_count_next = full_bit;
              bit_count_next  = '0;
            end else begin
              rx_mode_next = MODE_WAIT_START;
            end
          end
        end
        MODE_START_DELAY, MODE_DATA: begin
          if (rx_mode == MODE_START_DELAY) begin
            tick_count_next = dd_tick;
            bit_count_next  = dd_bit;
          end
          if ((rx_mode == MODE_START_DELAY && dd_done) ||
              (rx_mode == MODE_DATA && tick_count <= TICK_W'(1))) begin
            shift_bits_next  = tb_shift;
            ones_parity_next = tb_par;
            tick_count_next  = full_bit;
            if (tb_bc1 < FRAME_BITS) begin
              rx_mode_next   = MODE_DATA;
              bit_count_next = tb_bc1;
            end else begin
              rx_mode_next   = MODE_POST_DELAY;
              bit_count_next = '0;
              push           = 1'b1;
            end
          end else if (rx_mode == MODE_DATA) begin
            tick_count_next = tick_count - TICK_W'(1);
          end
        end
        MODE_WAIT_START, MODE_POST_DELAY: begin
          if (rx_mode == MODE_POST_DELAY && tick_count > TICK_W'(1)) begin
            tick_count_next = tick_count - TICK_W'(1);
          end else begin
            if (rx_mode == MODE_POST_DELAY) tick_count_next = '0;
            if (!rx_level) begin
              rx_mode_next     = MODE_START_DELAY;
              tick_count_next  = half_bit;
              bit_count_next   = 4'd1;
              shift_bits_next  = '0;
              ones_parity_next = 1'b0;
            end else begin
              rx_mode_next = MODE_WAIT_START;
            end
          end
        end
        default: begin
          rx_mode_next = MODE_HUNT_LOW;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_mode     <= MODE_HUNT_LOW;
      tick_count  <= '0;
      bit_count   <= '0;
      shift_bits  <= '0;
      ones_parity <= 1'b0;
    end else begin
      rx_mode     <= rx_mode_next;
      tick_count  <= tick_count_next;
      bit_count   <= bit_count_next;
      shift_bits  <= shift_bits_next;
      ones_parity <= ones_parity_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/upr_queue.sv -----
`default_nettype none
module upr_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire upr_pkg::byte_rec_t push_rec,
  input  wire logic               pop,
  output upr_pkg::byte_rec_t      head,
  output logic                    empty,
  output logic                    full
);
  import upr_pkg::*;

  byte_rec_t           slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  // Entry storage; the front never pushes while the queue is full.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_rec;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (pop) rd_ptr <= rd_ptr + QUEUE_AW'(1);
      if (push && !pop) count <= count + (QUEUE_AW+1)'(1);
      else if (pop && !push) count <= count - (QUEUE_AW+1)'(1);
    end
  end

endmodule
`default_nettype wire

// ----- src/upr_back.sv -----
`default_nettype none
module upr_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire upr_pkg::byte_rec_t          head,
  input  wire logic                        empty,
  output logic                             pop,
  input  wire logic [upr_pkg::BYTE_W-1:0]  header_byte,
  input  wire logic [upr_pkg::BYTE_W-1:0]  packet_length,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [upr_pkg::BYTE_W-1:0]       byte_value,
  output logic [upr_pkg::BYTE_W-1:0]       byte_index,
  output logic                             last_of_packet,
  output logic                             parity_error
);
  import upr_pkg::*;

  logic [BYTE_W-1:0] packet_position, packet_position_next;
  logic              load_en, keep, last;
  logic [BYTE_W:0]   len, pos_plus;

  // The output register takes a new beat when empty or being drained.
  assign load_en = !out_valid || !out_stall;
  assign pop     = load_en && !empty;

  // Header check on the first byte, and end of packet detection.
  assign keep     = (packet_position != '0) || (head.value == header_byte);
  assign len      = (packet_length == '0) ? (BYTE_W+1)'(1) : {1'b0, packet_length};
  assign pos_plus = {1'b0, packet_position} + (BYTE_W+1)'(1);
  assign last     = (pos_plus >= len);

  always_comb begin
    packet_position_next = packet_position;
    if (pop && keep) packet_position_next = last ? '0 : pos_plus[BYTE_W-1:0];
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (pop && keep) begin
      byte_value     <= head.value;
      byte_index     <= packet_position;
      last_of_packet <= last;
      parity_error   <= head.perr;
    end
  end

  // Output valid and packet position.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      packet_position <= '0;
    end else begin
      if (load_en) out_valid <= pop && keep;
      packet_position <= packet_position_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/uart_packet_receiver.sv -----
`default_nettype none
// Serial receiver for frames of eight data bits plus a parity bit, MSB first,
// with two stop bits, taking one line sample per clock on the input channel.
// After reset it hunts for frame alignment by checking both stop bits, then
// samples each character at mid-bit; a character with an odd count of ones is
// delivered as zero with parity_error set. Characters are grouped into packets
// of packet_length bytes whose first byte must equal header_byte; a first byte
// that does not match is dropped. The block takes one sample every cycle: the
// bit receiver advances once per beat, and it stalls the input only when the
// four-entry byte queue in front of the packet framer is full, which happens
// only after the output side has stalled for several characters. The framer
// drains one byte per cycle into an output register unless out_stall holds
// it. A new bit_ticks value applies from the next tick reload, even mid-delay.
module uart_packet_receiver (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [upr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [upr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            rx_level,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [upr_pkg::BYTE_W-1:0]           byte_value,
  output logic [upr_pkg::BYTE_W-1:0]           byte_index,
  output logic                                 last_of_packet,
  output logic                                 parity_error
);
  import upr_pkg::*;

  logic [TICK_W-1:0] bit_ticks;
  logic [BYTE_W-1:0] header_byte;
  logic [BYTE_W-1:0] packet_length;

  logic      accept, push, pop, q_empty, q_full;
  byte_rec_t push_rec, head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks     <= TICK_W'(10);
      header_byte   <= BYTE_W'(1);
      packet_length <= BYTE_W'(10);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BIT_TICKS:     bit_ticks     <= cfg_data[TICK_W-1:0];
        REG_HEADER_BYTE:   header_byte   <= cfg_data[BYTE_W-1:0];
        REG_PACKET_LENGTH: packet_length <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input beats are held off only while the byte queue is full.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  upr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_level  (rx_level),
    .bit_ticks (bit_ticks),
    .push      (push),
    .rec       (push_rec)
  );

  upr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  upr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .empty          (q_empty),
    .pop            (pop),
    .header_byte    (header_byte),
    .packet_length  (packet_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .byte_value     (byte_value),
    .byte_index     (byte_index),
    .last_of_packet (last_of_packet),
    .parity_error   (parity_error)
  );

endmodule
`default_nettype wire
